/* design/dibr_pkg.sv */
// Shared types, constants and the depth-to-disparity mapping for the anaglyph row warp.
`timescale 1ns / 1ps

package dibr_pkg;

	localparam int COL_W   = 10;
	localparam int CHAN_W  = 8;
	localparam int PIX_W   = 3 * CHAN_W;
	localparam int AWID_W  = 11;
	localparam int DRAW_W  = 5;
	localparam int N_THR   = 17;

	localparam logic       CMD_LOAD = 1'b0;
	localparam logic       CMD_READ = 1'b1;
	localparam logic [AWID_W-1:0] AWID_RESET = 11'd1024;

	// smallest depth code reaching each disparity step
	localparam logic [CHAN_W-1:0] DISP_THR [N_THR] = '{
		8'd7,   8'd20,  8'd34,  8'd48,  8'd62,  8'd76,  8'd90,  8'd105, 8'd120,
		8'd135, 8'd151, 8'd167, 8'd183, 8'd199, 8'd216, 8'd233, 8'd251
	};

	typedef struct packed {
		logic              command;
		logic [COL_W-1:0]  column;
		logic [CHAN_W-1:0] in_blue;
		logic [CHAN_W-1:0] in_green;
		logic [CHAN_W-1:0] in_red;
		logic [CHAN_W-1:0] depth_code;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_blue;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_red;
	} out_item_t;

	typedef struct packed {
		logic clear;
		logic step;
	} view_ctl_t;

	// round(117.3285*c/(1530+c)) as a count of thresholds passed
	function automatic logic [DRAW_W-1:0] disparity_of(input logic [CHAN_W-1:0] c);
		logic [DRAW_W-1:0] d;
		d = '0;
		for (int k = 0; k < N_THR; k++) begin
			if (c >= DISP_THR[k]) begin
				d = d + DRAW_W'(1);
			end
		end
		return d;
	endfunction

endpackage

/* design/dibr_row_store.sv */
// Row store: one write port, two registered read ports.
`timescale 1ns / 1ps

module dibr_row_store import dibr_pkg::*; #(
	parameter int DEPTH  = 1024,
	parameter int DATA_W = 29,
	parameter int AW     = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr_a,
	input  logic [AW-1:0]     rd_addr_b,
	output logic [DATA_W-1:0] rd_data_a,
	output logic [DATA_W-1:0] rd_data_b
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

/* design/dibr_view_unit.sv */
// One warped view: disparity match and first-hit select into the view register.
`timescale 1ns / 1ps

module dibr_view_unit import dibr_pkg::*; #(
	parameter int DW = 5
) (
	input  logic             clk,
	input  view_ctl_t        ctl,
	input  logic             src_ok,
	input  logic [DW-1:0]    step_m,
	input  logic [DW-1:0]    entry_disp,
	input  logic [PIX_W-1:0] entry_pix,
	output logic [PIX_W-1:0] view
);

	logic [PIX_W-1:0] view_q;
	logic             hit;

	assign hit  = ctl.step && src_ok && (entry_disp == step_m) && (view_q[CHAN_W-1:0] == '0);
	assign view = view_q;

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			view_q <= '0;
		end else if (hit) begin
			view_q <= entry_pix;
		end
	end

endmodule

/* design/dibr_anaglyph_row_warp_unit.sv */
// Top level: row warp to a red/cyan anaglyph pixel, with sequencer and config register.
//
// Usage
//   in channel  : in_valid/in_ready, payload in_data. A load (command 0) writes the
//                 pixel and its disparity into the row store in the accepting cycle
//                 and produces no transaction on the out channel. A read (command 1)
//                 produces exactly one out transaction.
//   out channel : out_valid/out_ready, payload out_data, held in an output register.
//   cfg channel : cfg_valid/cfg_ready, cfg_data is the active row width; always ready.
// Timing
//   A read walks MAX_DISPARITY+1 candidate offsets, both views at once through the two
//   read ports of the row store, one offset per cycle; a drain state and a done state
//   follow, and the result enters the output register once it is free. No new item
//   is taken until the read has finished; a load leaves the unit idle.
// Reset
//   arst_n clears the sequencer, the handshakes and sets the row width to 1024. The
//   row store is not cleared; reading an unloaded column gives undefined data.
// Back-pressure
//   A finished read waits until the output register is free; input is accepted while
//   an earlier result still waits to be taken.
`timescale 1ns / 1ps

module dibr_anaglyph_row_warp_unit import dibr_pkg::*; #(
	parameter int MAX_WIDTH     = 1024,
	parameter int MAX_DISPARITY = 17
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [AWID_W-1:0] cfg_data
);

	localparam int AW     = $clog2(MAX_WIDTH);
	localparam int DW     = $clog2(MAX_DISPARITY + 1);
	localparam int MAX_CA = (COL_W > AW) ? COL_W : AW;
	localparam int SUM_W  = ((MAX_CA > DW) ? MAX_CA : DW) + 1;
	localparam int ENT_W  = DW + PIX_W;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_WALK  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0]        state_q;
	logic [AWID_W-1:0] active_width_q;
	logic [AWID_W-1:0] eff_width;
	logic [SUM_W-1:0]  width_x;
	logic [COL_W-1:0]  target_q;
	logic              target_ok_q;
	logic [DW-1:0]     m_q;
	logic [DW-1:0]     m_s1;
	logic              step_s1;
	logic              rok_s1;
	logic              lok_s1;
	logic              out_valid_q;
	out_item_t         out_q;

	logic              accept;
	logic              load_go;
	logic              read_go;
	logic              walk;
	logic              last_m;
	logic              emit;
	logic [SUM_W-1:0]  col_x;
	logic [SUM_W-1:0]  tgt_x;
	logic [SUM_W-1:0]  m_x;
	logic [SUM_W-1:0]  right_src;
	logic [SUM_W-1:0]  left_src;
	logic              right_ok;
	logic              left_ok;
	logic [DRAW_W-1:0] disp_raw;
	logic [DW-1:0]     disp_sat;
	logic [ENT_W-1:0]  wr_entry;
	logic [ENT_W-1:0]  ent_r;
	logic [ENT_W-1:0]  ent_l;
	logic [PIX_W-1:0]  view_r;
	logic [PIX_W-1:0]  view_l;
	view_ctl_t         vctl_r;
	view_ctl_t         vctl_l;

	assign eff_width = (int'(active_width_q) > MAX_WIDTH) ? AWID_W'(MAX_WIDTH) : active_width_q;
	assign width_x   = SUM_W'(eff_width);

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign col_x     = SUM_W'(in_data.column);
	assign load_go   = accept && (in_data.command == CMD_LOAD) && (int'(in_data.column) < MAX_WIDTH);
	assign read_go   = accept && (in_data.command == CMD_READ);

	assign disp_raw  = disparity_of(in_data.depth_code);
	assign disp_sat  = (int'(disp_raw) > MAX_DISPARITY) ? DW'(MAX_DISPARITY) : DW'(disp_raw);
	assign wr_entry  = {disp_sat, in_data.in_red, in_data.in_green, in_data.in_blue};

	assign walk      = (state_q == S_WALK);
	assign last_m    = (m_q == DW'(MAX_DISPARITY));
	assign tgt_x     = SUM_W'(target_q);
	assign m_x       = SUM_W'(m_q);
	assign right_ok  = (tgt_x >= m_x);
	assign right_src = tgt_x - m_x;
	assign left_src  = tgt_x + m_x;
	assign left_ok   = (left_src < width_x);

	assign emit      = (state_q == S_DONE) && (!out_valid_q || out_ready);

	dibr_row_store #(
		.DEPTH  (MAX_WIDTH),
		.DATA_W (ENT_W)
	) u_store (
		.clk       (clk),
		.wr_en     (load_go),
		.wr_addr   (col_x[AW-1:0]),
		.wr_data   (wr_entry),
		.rd_en     (walk),
		.rd_addr_a (right_src[AW-1:0]),
		.rd_addr_b (left_src[AW-1:0]),
		.rd_data_a (ent_r),
		.rd_data_b (ent_l)
	);

	assign vctl_r = '{clear: read_go, step: step_s1};
	assign vctl_l = '{clear: read_go, step: step_s1};

	dibr_view_unit #(.DW(DW)) u_right (
		.clk        (clk),
		.ctl        (vctl_r),
		.src_ok     (rok_s1),
		.step_m     (m_s1),
		.entry_disp (ent_r[ENT_W-1:PIX_W]),
		.entry_pix  (ent_r[PIX_W-1:0]),
		.view       (view_r)
	);

	dibr_view_unit #(.DW(DW)) u_left (
		.clk        (clk),
		.ctl        (vctl_l),
		.src_ok     (lok_s1),
		.step_m     (m_s1),
		.entry_disp (ent_l[ENT_W-1:PIX_W]),
		.entry_pix  (ent_l[PIX_W-1:0]),
		.view       (view_l)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_width_q <= AWID_RESET;
		end else if (cfg_valid && cfg_ready) begin
			active_width_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			m_q     <= '0;
			step_s1 <= 1'b0;
		end else begin
			step_s1 <= walk;
			unique case (state_q)
				S_IDLE: begin
					m_q <= '0;
					if (read_go) begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					m_q <= m_q + DW'(1);
					if (last_m) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (read_go) begin
			target_q    <= in_data.column;
			target_ok_q <= (col_x < width_x);
		end
		m_s1   <= m_q;
		rok_s1 <= right_ok;
		lok_s1 <= left_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (target_ok_q) begin
				out_q.out_blue  <= view_r[CHAN_W-1:0];
				out_q.out_green <= view_r[2*CHAN_W-1:CHAN_W];
				out_q.out_red   <= view_l[PIX_W-1:2*CHAN_W];
			end else begin
				out_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* tb/dibr_anaglyph_row_warp_unit_tb.sv */
// Self-checking testbench for the anaglyph row warp unit: row loads, warped reads, width register.
`timescale 1ns / 1ps

class anaglyph_scoreboard;
	localparam int ROW_DEPTH = 1024;
	localparam int DISP_MAX  = 17;

	logic [dibr_pkg::PIX_W-1:0]  row_pix [ROW_DEPTH];
	logic [dibr_pkg::DRAW_W-1:0] row_disp [ROW_DEPTH];
	int unsigned                 row_width;
	dibr_pkg::out_item_t         expected_anaglyph [$];
	int                          errors;

	function new();
		row_width = dibr_pkg::AWID_RESET;
		errors = 0;
		foreach (row_pix[i]) begin
			row_pix[i] = '0;
			row_disp[i] = '0;
		end
	endfunction

	function void set_width(logic [dibr_pkg::AWID_W-1:0] w);
		row_width = w;
	endfunction

	function int pending();
		return expected_anaglyph.size();
	endfunction

	// nearest integer of 32500*c / (277*(1530+c)), clipped to the largest shift
	function logic [dibr_pkg::DRAW_W-1:0] shift_from_depth(logic [7:0] c);
		int unsigned den;
		int unsigned q;
		den = 1530 + c;
		q = (65000 * c + 277 * den) / (554 * den);
		if (q > DISP_MAX)
			q = DISP_MAX;
		return q[dibr_pkg::DRAW_W-1:0];
	endfunction

	function logic [dibr_pkg::PIX_W-1:0] warp_view(int t, int dir, int w);
		logic [dibr_pkg::PIX_W-1:0] v;
		int s;
		v = '0;
		for (int m = 0; m <= DISP_MAX; m++) begin
			s = t + dir * m;
			if (s >= 0 && s < w && row_disp[s] == m && v[7:0] == 8'd0)
				v = row_pix[s];
		end
		return v;
	endfunction

	function void note_input(dibr_pkg::in_item_t it);
		dibr_pkg::out_item_t r;
		logic [dibr_pkg::PIX_W-1:0] right_px, left_px;
		int w;
		w = (row_width > ROW_DEPTH) ? ROW_DEPTH : row_width;
		if (it.command == dibr_pkg::CMD_LOAD) begin
			row_pix[it.column] = {it.in_red, it.in_green, it.in_blue};
			row_disp[it.column] = shift_from_depth(it.depth_code);
			return;
		end
		r = '0;
		if (it.column < w) begin
			right_px = warp_view(it.column, -1, w);
			left_px = warp_view(it.column, 1, w);
			r.out_blue = right_px[7:0];
			r.out_green = right_px[15:8];
			r.out_red = left_px[23:16];
		end
		expected_anaglyph.push_back(r);
	endfunction

	function void check_result(dibr_pkg::out_item_t got);
		dibr_pkg::out_item_t exp_px;
		if (expected_anaglyph.size() == 0) begin
			$display("%0t: unexpected result transaction %h", $time, got);
			errors++;
			return;
		end
		exp_px = expected_anaglyph.pop_front();
		if (got.out_blue !== exp_px.out_blue) begin
			$display("%0t: out_blue expected %0d actual %0d", $time, exp_px.out_blue,
				got.out_blue);
			errors++;
		end
		if (got.out_green !== exp_px.out_green) begin
			$display("%0t: out_green expected %0d actual %0d", $time, exp_px.out_green,
				got.out_green);
			errors++;
		end
		if (got.out_red !== exp_px.out_red) begin
			$display("%0t: out_red expected %0d actual %0d", $time, exp_px.out_red,
				got.out_red);
			errors++;
		end
	endfunction
endclass

module dibr_anaglyph_row_warp_unit_tb;
	import dibr_pkg::*;

	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_ITEMS  = 54;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	in_item_t           in_data;
	logic               out_valid;
	logic               out_ready;
	out_item_t          out_data;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [AWID_W-1:0]  cfg_data;

	anaglyph_scoreboard sb;
	bit                 loaded [1024];
	int unsigned        send_idle_pct;
	int unsigned        recv_idle_pct;

	dibr_anaglyph_row_warp_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// valid is left high after a transaction so back-to-back items are sent without dropping valid
	task automatic send_item(input in_item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(it);
	endtask

	task automatic load_pixel(input int c, input logic [7:0] b, input logic [7:0] g,
			input logic [7:0] r, input logic [7:0] d);
		in_item_t it;
		it.command = CMD_LOAD;
		it.column = COL_W'(c);
		it.in_blue = b;
		it.in_green = g;
		it.in_red = r;
		it.depth_code = d;
		loaded[c] = 1'b1;
		send_item(it);
	endtask

	task automatic load_random(input int c);
		logic [7:0] b, d;
		b = ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom_range(255));
		case ($urandom_range(7))
			0: d = 8'd0;
			1: d = 8'd255;
			default: d = 8'($urandom_range(255));
		endcase
		load_pixel(c, b, 8'($urandom_range(255)), 8'($urandom_range(255)), d);
	endtask

	task automatic read_pixel(input int t);
		in_item_t it;
		it = in_item_t'({$urandom, $urandom});
		it.command = CMD_READ;
		it.column = COL_W'(t);
		send_item(it);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_width(input logic [AWID_W-1:0] w);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= w;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.set_width(w);
	endtask

	// for a read inside the row, every source it can use is loaded first, so no unwritten entry reaches a result
	task automatic row_phase(input int unsigned w);
		int weff, span, win, n, t, lo, hi;
		weff = (w > 1024) ? 1024 : w;
		span = (weff == 0) ? 1 : ((weff < 64) ? weff : 64);
		win = (weff > 64) ? $urandom_range(weff - 64) : 0;
		n = 0;
		while (n < PHASE_ITEMS) begin
			if ($urandom_range(99) < 45) begin
				if ($urandom_range(5) == 0)
					load_random($urandom_range(1023));
				else
					load_random(win + $urandom_range(span - 1));
				n++;
			end else begin
				if ($urandom_range(7) == 0)
					t = $urandom_range(1023);
				else
					t = win + $urandom_range(span + 3);
				if (t > 1023)
					t = 1023;
				if (t < weff) begin
					lo = (t < 17) ? 0 : t - 17;
					hi = (t + 17 > weff - 1) ? weff - 1 : t + 17;
					for (int c = lo; c <= hi; c++) begin
						if (!loaded[c]) begin
							load_random(c);
							n++;
						end
					end
				end
				read_pixel(t);
				n++;
			end
		end
	endtask

	initial begin
		int unsigned widths [12];
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		send_idle_pct = 21;
		recv_idle_pct = 75;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short row: shifts from depth 0 up to 255, blue-zero holes, extreme colours
		write_width(11'd20);
		for (int k = 0; k < 20; k++)
			load_pixel(k, (k % 3 == 0) ? 8'd0 : 8'hFF ^ 8'(k * 17), 8'(k * 13),
				8'hFF - 8'(k * 13), 8'((k * 255) / 19));
		load_pixel(25, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		read_pixel(0);
		read_pixel(19);
		read_pixel(9);
		read_pixel(20);
		read_pixel(1023);

		widths = '{1024, 37, 0, 1, 2047, 18, $urandom_range(63, 2), 1000,
			$urandom_range(1024, 1), 1024, 64, 2047};
		for (int p = 0; p < 12; p++) begin
			if (p == 4) begin
				wait_idle();
				send_idle_pct = 75;
				recv_idle_pct = 21;
			end else if (p == 8) begin
				wait_idle();
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_width(AWID_W'(widths[p]));
			row_phase(widths[p]);
		end

		wait_idle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("dibr_anaglyph_row_warp_unit verification clean");
		else
			$display("dibr_anaglyph_row_warp_unit verification failed");
		$finish;
	end

	initial begin
		#4000000;
		$display("dibr_anaglyph_row_warp_unit verification failed");
		$finish;
	end
endmodule
